// ----- design/tpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpfd_pkg
// Shared types and constants for the touch point frame decoder.
// ----------------------------------------------------------------------------
package tpfd_pkg;

    localparam int DefFingers = 5;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 13;
    localparam int CoordW   = 12;
    localparam int IdW      = 5;
    localparam int SlotW    = 3;
    localparam int KindW    = 2;

    localparam logic [CfgIdxW-1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PANEL_HEIGHT = 2'd1;

    localparam logic [CfgDataW-1:0] PANEL_WIDTH_RST  = 13'd1200;
    localparam logic [CfgDataW-1:0] PANEL_HEIGHT_RST = 13'd1920;

    localparam logic [KindW-1:0] KIND_CONTACT = 2'd0;
    localparam logic [KindW-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KindW-1:0] KIND_SYNC    = 2'd2;

    localparam logic [2:0] STATUS_DOWN_A = 3'd1;
    localparam logic [2:0] STATUS_DOWN_B = 3'd2;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load_rec;
        logic emit_contact;
        logic emit_release;
        logic emit_sync;
        logic clr_idx;
        logic inc_idx;
    } tpfd_cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic rec_valid;
        logic rec_end;
        logic rel_hit;
        logic idx_last;
        logic out_free;
    } tpfd_sts_t;

endpackage

// ----- design/touch_point_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// touch_point_frame_decoder
// Multitouch slot tracker: finger records in, contact/release/sync beats out.
// ----------------------------------------------------------------------------
// One input beat is one finger record. The record is registered when taken
// and checked in the EVAL state (id in 1..FINGERS, status 1 or 2, x and y
// inside the panel limits). A good record yields a contact beat for slot
// id-1. A record with tlast set then runs the release scan, one slot per
// cycle unless a release beat waits for the result register, and ends with
// a sync beat. While m_tready low holds the result register, the contact,
// release and sync beats wait. The result register decouples the two sides,
// so a new record is taken while the last beat is still waiting. m_tlast
// marks the final beat caused by a record; rejected records without tlast
// make no beat at all. The user must write the panel limits over the cfg
// channel only while the block is idle; the block does not enforce this.
// Indexes other than 0 and 1 are ignored.
// ----------------------------------------------------------------------------
module touch_point_frame_decoder
    import tpfd_pkg::*;
#(
    parameter int FINGERS = DefFingers
)
(
    input  logic                clk,
    input  logic                rst_n,
    // record stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // header_byte, x_high_byte, y_high_byte, low_nibbles
    input  logic                s_tlast,   // frame_end
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // slot[2:0], pos_x[14:3], pos_y[26:15], zero fill
    output logic [KindW-1:0]    m_tuser,   // report_kind
    output logic                m_tlast,   // last
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    tpfd_cmd_t cmd;
    tpfd_sts_t sts;

    // registers are always writable
    assign cfg_ready = 1'b1;

    tpfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tpfd_datapath #(
        .FINGERS (FINGERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_data  (s_tdata),
        .rec_last  (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ----- design/tpfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpfd_ctrl
// Sequencer: record evaluation, release scan and frame-end sync.
// ----------------------------------------------------------------------------
module tpfd_ctrl
    import tpfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tpfd_sts_t sts,
    output tpfd_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_SYNC = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_rec = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!sts.rec_valid || sts.out_free)
                begin
                    cmd.emit_contact = sts.rec_valid;
                    cmd.clr_idx      = 1'b1;
                    state_next       = sts.rec_end ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!sts.rel_hit || sts.out_free)
                begin
                    cmd.emit_release = sts.rel_hit;
                    if (sts.idx_last)
                    begin
                        state_next = ST_SYNC;
                    end
                    else
                    begin
                        cmd.inc_idx = 1'b1;
                    end
                end
            end
            ST_SYNC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sync = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/tpfd_datapath.sv -----
// ----------------------------------------------------------------------------
// tpfd_datapath
// Record register, panel limits, slot masks, scan index and result register.
// ----------------------------------------------------------------------------
module tpfd_datapath
    import tpfd_pkg::*;
#(
    parameter int FINGERS = DefFingers
)
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    // record
    input  logic [31:0]         rec_data,
    input  logic                rec_last,
    // sequencer
    input  tpfd_cmd_t           cmd,
    output tpfd_sts_t           sts,
    // result
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_data,
    output logic [KindW-1:0]    out_kind,
    output logic                out_last
);

    localparam int IdxW = (FINGERS > 1) ? $clog2(FINGERS) : 1;

    logic [CfgDataW-1:0] panel_w_reg;
    logic [CfgDataW-1:0] panel_h_reg;
    logic [FINGERS-1:0]  seen_reg;
    logic [FINGERS-1:0]  down_reg;
    logic [FINGERS-1:0]  seen_next;
    logic [IdxW-1:0]     idx_reg;

    logic [7:0]          hdr_reg;
    logic [CoordW-1:0]   x_reg;
    logic [CoordW-1:0]   y_reg;
    logic                end_reg;

    logic                ovalid_reg;
    logic                ovalid_next;
    logic [KindW-1:0]    okind_reg;
    logic [SlotW-1:0]    oslot_reg;
    logic [CoordW-1:0]   ox_reg;
    logic [CoordW-1:0]   oy_reg;
    logic                olast_reg;

    logic [IdW-1:0]      id;
    logic [IdW-1:0]      id_m1;
    logic [2:0]          status;
    logic [IdW-1:0]      idx_wide;
    logic                emit_any;

    assign id       = hdr_reg[7:3];
    assign id_m1    = id - IdW'(1);
    assign status   = hdr_reg[2:0];
    assign idx_wide = IdW'(idx_reg);
    assign emit_any = cmd.emit_contact | cmd.emit_release | cmd.emit_sync;

    assign sts.rec_valid = (id != '0) && (id <= IdW'(FINGERS))
                         && (status == STATUS_DOWN_A || status == STATUS_DOWN_B)
                         && ({1'b0, x_reg} < panel_w_reg)
                         && ({1'b0, y_reg} < panel_h_reg);
    assign sts.rec_end   = end_reg;
    assign sts.rel_hit   = down_reg[idx_reg] & ~seen_reg[idx_reg];
    assign sts.idx_last  = (idx_reg == IdxW'(FINGERS - 1));
    assign sts.out_free  = ~ovalid_reg | out_ready;

    always_comb
    begin
        seen_next = seen_reg;
        if (cmd.emit_contact)
        begin
            for (int i = 0; i < FINGERS; i++)
            begin
                if (id_m1 == IdW'(i))
                begin
                    seen_next[i] = 1'b1;
                end
            end
        end
        if (cmd.emit_sync)
        begin
            seen_next = '0;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg & ~out_ready;
        if (emit_any)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_w_reg <= PANEL_WIDTH_RST;
            panel_h_reg <= PANEL_HEIGHT_RST;
            seen_reg    <= '0;
            down_reg    <= '0;
            idx_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_PANEL_WIDTH)
            begin
                panel_w_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_PANEL_HEIGHT)
            begin
                panel_h_reg <= cfg_data;
            end
            seen_reg <= seen_next;
            if (cmd.emit_sync)
            begin
                down_reg <= seen_reg;
            end
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + IdxW'(1);
            end
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_rec)
        begin
            hdr_reg <= rec_data[7:0];
            x_reg   <= {rec_data[15:8], rec_data[31:28]};
            y_reg   <= {rec_data[23:16], rec_data[27:24]};
            end_reg <= rec_last;
        end
        if (cmd.emit_contact)
        begin
            okind_reg <= KIND_CONTACT;
            oslot_reg <= id_m1[SlotW-1:0];
            ox_reg    <= x_reg;
            oy_reg    <= y_reg;
            olast_reg <= ~end_reg;
        end
        else if (cmd.emit_release)
        begin
            okind_reg <= KIND_RELEASE;
            oslot_reg <= idx_wide[SlotW-1:0];
            ox_reg    <= '0;
            oy_reg    <= '0;
            olast_reg <= 1'b0;
        end
        else if (cmd.emit_sync)
        begin
            okind_reg <= KIND_SYNC;
            oslot_reg <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            olast_reg <= 1'b1;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;
    assign out_data  = {5'b0, oy_reg, ox_reg, oslot_reg};

endmodule

// ----- design/tpfd_checker.sv -----
// ----------------------------------------------------------------------------
// tpfd_checker
// Port-level checks for the touch point frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module tpfd_checker
    import tpfd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [31:0]         m_tdata,
    input logic [KindW-1:0]    m_tuser,
    input logic                m_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // one record at a time: no accept right after an accept
    a_one_rec: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("record accepted during evaluation");

    // a sync always closes the record's beats, a release never does
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_SYNC) == m_tlast)
            || (m_tuser == KIND_CONTACT))
        else $error("tlast does not match report kind");

    // release and sync carry no position
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_CONTACT |-> m_tdata[26:3] == '0)
        else $error("non-contact beat has a position");

endmodule

bind touch_point_frame_decoder tpfd_checker u_tpfd_checker (.*);
